### rtl/core/ieucf_pkg.sv
// ----------------------------------------------------------------------------
// Implicit Euler Coulomb friction package
// Shared types, register indexes and sequencing step codes.
// ----------------------------------------------------------------------------
package ieucf_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam int unsigned STEP_WIDTH      = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COULOMB   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VISCOUS   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STIFFNESS = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD    = 2'd3;

   localparam logic [31:0] PERIOD_RESET = 32'd4294967;

   localparam logic [STEP_WIDTH-1:0] STEP_KDT = 4'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_BF  = 4'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_WST = 4'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_TST = 4'd3;
   localparam logic [STEP_WIDTH-1:0] STEP_H   = 4'd4;
   localparam logic [STEP_WIDTH-1:0] STEP_CTC = 4'd5;
   localparam logic [STEP_WIDTH-1:0] STEP_FR  = 4'd6;
   localparam logic [STEP_WIDTH-1:0] STEP_EA  = 4'd7;
   localparam logic [STEP_WIDTH-1:0] STEP_EB  = 4'd8;

   typedef struct packed {
      logic [30:0] coulomb_level;
      logic [30:0] viscous_gain;
      logic [30:0] spring_stiffness;
      logic [31:0] step_period;
   } cfg_type;

   typedef struct packed {
      logic                  load_item;
      logic                  mul_start;
      logic                  div_start;
      logic                  write_back;
      logic                  out_load;
      logic [STEP_WIDTH-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic step_uses_mul(input logic [STEP_WIDTH-1:0] step);
      return step != STEP_BF;
   endfunction

   function automatic logic step_uses_div(input logic [STEP_WIDTH-1:0] step);
      return (step != STEP_TST) && (step != STEP_FR);
   endfunction

endpackage

### rtl/core/ieucf_if.sv
// ----------------------------------------------------------------------------
// Implicit Euler Coulomb friction channels
// Valid/ready channels for samples, torques and register writes.
// ----------------------------------------------------------------------------
interface ieucf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] joint_velocity;
   modport source(output valid, output joint_velocity, input ready);
   modport sink(input valid, input joint_velocity, output ready);
endinterface

interface ieucf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] friction_torque;
   modport source(output valid, output friction_torque, input ready);
   modport sink(input valid, input friction_torque, output ready);
endinterface

interface ieucf_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [ieucf_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [ieucf_pkg::CSR_DATA_WIDTH-1:0]  data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/core/ieucf_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Radix-2 shift-add 64x64 multiplier; product clamped to 2^63-1.
// ----------------------------------------------------------------------------
module ieucf_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [62:0] product
);

   logic        busy_ff;
   logic [5:0]  count_ff;
   logic [63:0] a_ff;
   logic [63:0] b_ff;
   logic [63:0] hi_ff;
   logic [63:0] lo_ff;
   logic [64:0] sum;

   assign sum = {1'b0, hi_ff} + (b_ff[0] ? {1'b0, a_ff} : 65'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + 6'd1;
         if (count_ff == 6'd63) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         b_ff  <= b;
         hi_ff <= '0;
         lo_ff <= '0;
      end else if (busy_ff) begin
         hi_ff <= sum[64:1];
         lo_ff <= {sum[0], lo_ff[63:1]};
         b_ff  <= {1'b0, b_ff[63:1]};
      end
   end

   assign done    = !busy_ff;
   assign product = ((hi_ff != 64'd0) || lo_ff[63]) ? {63{1'b1}} : lo_ff[62:0];

endmodule

### rtl/core/ieucf_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ieucf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quot
);

   logic        busy_ff;
   logic [5:0]  count_ff;
   logic [63:0] q_ff;
   logic [63:0] rem_ff;
   logic [63:0] d_ff;
   logic [64:0] shifted;
   logic [65:0] diff;
   logic        ge;

   assign shifted = {rem_ff, q_ff[63]};
   assign diff    = {1'b0, shifted} - {2'b00, d_ff};
   assign ge      = !diff[65];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + 6'd1;
         if (count_ff == 6'd63) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
         d_ff   <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[63:0] : shifted[63:0];
         q_ff   <= {q_ff[62:0], ge};
      end
   end

   assign done = !busy_ff;
   assign quot = q_ff;

endmodule

### rtl/core/ieucf_datapath.sv
// ----------------------------------------------------------------------------
// Friction datapath
// Working registers, operand selection and write-back for each step.
// ----------------------------------------------------------------------------
module ieucf_datapath #(
   parameter int unsigned SAT_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ieucf_pkg::cmd_type       cmd,
   input  ieucf_pkg::cfg_type       cfg,
   input  logic signed [31:0]       joint_velocity,
   output logic                     mul_done,
   output logic                     div_done,
   output logic signed [31:0]       friction_torque
);

   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
   localparam logic [63:0] ONE_Q48 = 64'h0001_0000_0000_0000;

   logic signed [31:0] w_ff;
   logic signed [31:0] defl_ff;
   logic [30:0]        kdt_ff;
   logic [49:0]        g_ff;
   logic signed [63:0] wst_ff;
   logic signed [47:0] tst_ff;
   logic [30:0]        h_ff;
   logic [30:0]        ctc_ff;
   logic signed [31:0] fr_ff;
   logic signed [32:0] ea_ff;

   logic [31:0] dt;
   logic [50:0] gv;
   logic [31:0] e_mag;
   logic [63:0] wst_mag;
   logic [31:0] fr_mag;
   logic [63:0] mul_a;
   logic [63:0] mul_b;
   logic [63:0] div_n;
   logic [63:0] div_d;
   logic [62:0] prod;
   logic [63:0] quot;
   logic [49:0] kb;
   logic [49:0] g_in;
   logic signed [47:0] s_scaled;
   logic signed [63:0] fr_pre;
   logic signed [63:0] defl_pre;
   logic signed [47:0] b_scaled;
   logic signed [47:0] t_scaled;

   function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end
      return r;
   endfunction

   assign dt      = (cfg.step_period == 32'd0) ? 32'd1 : cfg.step_period;
   assign gv      = {1'b0, g_ff} + 51'(cfg.viscous_gain);
   assign e_mag   = defl_ff[31] ? (~defl_ff + 32'd1) : defl_ff;
   assign wst_mag = wst_ff[63] ? (~wst_ff + 64'd1) : wst_ff;
   assign fr_mag  = fr_ff[31] ? (~fr_ff + 32'd1) : fr_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_n = {1'b0, prod};
      div_d = 64'd1;
      case (cmd.step)
         ieucf_pkg::STEP_KDT: begin
            mul_a = 64'(cfg.spring_stiffness);
            mul_b = 64'(dt);
         end
         ieucf_pkg::STEP_BF: begin
            div_n = ONE_Q48;
            div_d = 64'(dt);
         end
         ieucf_pkg::STEP_WST: begin
            mul_a = 64'(e_mag);
            mul_b = 64'(cfg.spring_stiffness);
            div_d = 64'(g_ff);
         end
         ieucf_pkg::STEP_TST: begin
            mul_a = wst_mag;
            mul_b = 64'(g_ff);
         end
         ieucf_pkg::STEP_H: begin
            mul_a = 64'(cfg.viscous_gain);
            mul_b = 64'(cfg.viscous_gain);
            div_d = 64'(gv);
         end
         ieucf_pkg::STEP_CTC: begin
            mul_a = 64'(cfg.coulomb_level);
            mul_b = 64'(cfg.viscous_gain);
            div_d = 64'(gv);
         end
         ieucf_pkg::STEP_FR: begin
            mul_a = wst_mag;
            mul_b = 64'(h_ff);
         end
         ieucf_pkg::STEP_EA: begin
            mul_a = 64'(e_mag);
            mul_b = 64'(kdt_ff);
            div_d = 64'(g_ff);
         end
         ieucf_pkg::STEP_EB: begin
            mul_a = 64'(fr_mag);
            mul_b = 64'(dt);
            div_d = 64'(g_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   ieucf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   ieucf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_n),
      .den   (div_d),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      kb   = 50'(kdt_ff) + 50'(quot[48:0]);
      g_in = (51'(cfg.viscous_gain) >= 51'(kb)) ? (50'(cfg.viscous_gain) + 50'd1) : kb;

      t_scaled = wst_ff[63] ? -$signed({1'b0, prod[62:16]}) : $signed({1'b0, prod[62:16]});
      s_scaled = t_scaled;

      if (48'(tst_ff) > $signed(48'(cfg.coulomb_level))) begin
         fr_pre = 64'($signed({1'b0, ctc_ff})) + 64'(s_scaled);
      end else if (tst_ff < -$signed(48'(cfg.coulomb_level))) begin
         fr_pre = -64'($signed({1'b0, ctc_ff})) + 64'(s_scaled);
      end else begin
         fr_pre = 64'(tst_ff);
      end

      b_scaled = fr_ff[31] ? -$signed(quot[63:16]) : $signed(quot[63:16]);
      defl_pre = 64'(defl_ff) - 64'(ea_ff) + 64'(b_scaled);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         defl_ff <= '0;
      end else if (cmd.write_back && (cmd.step == ieucf_pkg::STEP_EB)) begin
         defl_ff <= 32'(sat_word(defl_pre));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         w_ff <= joint_velocity;
      end
      if (cmd.write_back) begin
         case (cmd.step)
            ieucf_pkg::STEP_KDT: kdt_ff <= prod[62:32];
            ieucf_pkg::STEP_BF:  g_ff <= g_in;
            ieucf_pkg::STEP_WST: begin
               wst_ff <= 64'(w_ff) + (defl_ff[31] ? -$signed({2'b00, quot[61:0]})
                                                  : $signed({2'b00, quot[61:0]}));
            end
            ieucf_pkg::STEP_TST: tst_ff <= t_scaled;
            ieucf_pkg::STEP_H:   h_ff <= cfg.viscous_gain - quot[30:0];
            ieucf_pkg::STEP_CTC: ctc_ff <= cfg.coulomb_level - quot[30:0];
            ieucf_pkg::STEP_FR:  fr_ff <= 32'(sat_word(fr_pre));
            ieucf_pkg::STEP_EA: begin
               ea_ff <= defl_ff[31] ? -$signed({1'b0, quot[31:0]})
                                    : $signed({1'b0, quot[31:0]});
            end
            default: begin
            end
         endcase
      end
   end

   assign friction_torque = fr_ff;

endmodule

### rtl/core/ieucf_ctrl.sv
// ----------------------------------------------------------------------------
// Friction controller
// Sequences the multiply, divide and write-back of every step, skipping the multiply or divide where a step uses none.
// ----------------------------------------------------------------------------
module ieucf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ieucf_pkg::status_type  status,
   output ieucf_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MUL_GO   = 3'd1;
   localparam logic [2:0] ST_MUL_WAIT = 3'd2;
   localparam logic [2:0] ST_DIV_GO   = 3'd3;
   localparam logic [2:0] ST_DIV_WAIT = 3'd4;
   localparam logic [2:0] ST_WB       = 3'd5;
   localparam logic [2:0] ST_OUT      = 3'd6;

   logic [2:0]                       state_ff;
   logic [2:0]                       state_in;
   logic [ieucf_pkg::STEP_WIDTH-1:0] step_ff;
   logic [ieucf_pkg::STEP_WIDTH-1:0] step_in;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.step       = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               step_in       = ieucf_pkg::STEP_KDT;
               state_in      = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (status.mul_done) begin
               state_in = ieucf_pkg::step_uses_div(step_ff) ? ST_DIV_GO : ST_WB;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            cmd.write_back = 1'b1;
            if (step_ff == ieucf_pkg::STEP_EB) begin
               state_in = ST_OUT;
            end else begin
               step_in  = step_ff + 4'd1;
               state_in = ieucf_pkg::step_uses_mul(step_in) ? ST_MUL_GO : ST_DIV_GO;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= ieucf_pkg::STEP_KDT;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### rtl/core/implicit_euler_coulomb_friction_unit.sv
// ----------------------------------------------------------------------------
// Implicit Euler Coulomb friction unit
// Each joint velocity sample yields one friction torque after its transfer:
// nine steps share one radix-2 multiplier and one restoring divider, and
// each operation is started and then waited on until its done flag returns.
// A new sample is taken once the previous torque has been placed in the
// output register, even while that torque still waits for its transfer.
// ----------------------------------------------------------------------------
module implicit_euler_coulomb_friction_unit #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   ieucf_req_if.sink   req_if,
   ieucf_rsp_if.source rsp_if,
   ieucf_csr_if.sink   csr_if
);

   localparam int unsigned SAT_WIDTH = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;

   ieucf_pkg::cfg_type    cfg_ff;
   ieucf_pkg::cmd_type    cmd;
   ieucf_pkg::status_type status;
   logic                  rsp_valid_ff;
   logic signed [31:0]    rsp_torque_ff;
   logic signed [31:0]    torque;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coulomb_level    <= '0;
         cfg_ff.viscous_gain     <= '0;
         cfg_ff.spring_stiffness <= '0;
         cfg_ff.step_period      <= ieucf_pkg::PERIOD_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            ieucf_pkg::CSR_COULOMB:   cfg_ff.coulomb_level    <= csr_if.data[30:0];
            ieucf_pkg::CSR_VISCOUS:   cfg_ff.viscous_gain     <= csr_if.data[30:0];
            ieucf_pkg::CSR_STIFFNESS: cfg_ff.spring_stiffness <= csr_if.data[30:0];
            ieucf_pkg::CSR_PERIOD:    cfg_ff.step_period      <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_if.ready;

   ieucf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ieucf_datapath #(
      .SAT_WIDTH (SAT_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg_ff),
      .joint_velocity  (req_if.joint_velocity),
      .mul_done        (status.mul_done),
      .div_done        (status.div_done),
      .friction_torque (torque)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_torque_ff <= torque;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.friction_torque = rsp_torque_ff;

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// Implicit Euler Coulomb friction unit testbench
// Sends joint velocity samples under several register settings and checks
// every friction torque against a bit-accurate predictor kept in the bench.
// Both channels idle at random, except during one calm phase.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned PROD_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int DRAIN_CYCLES = 1500;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ieucf_req_if req();
   ieucf_rsp_if rsp();
   ieucf_csr_if csr();

   implicit_euler_coulomb_friction_unit #(.DATA_WIDTH(32)) dut (
      .clock(clock), .reset(reset), .req_if(req), .rsp_if(rsp), .csr_if(csr)
   );

   always #5 clock = ~clock;

   logic signed [31:0] velocity_q[$];
   logic signed [31:0] torque_q[$];
   longint unsigned tc_r, tv_r, kf_r, dt_r;
   longint signed   defl_r;
   bit  calm = 1'b0;
   int  mismatches = 0;
   int  torques_seen = 0;
   int  samples_sent = 0;
   int  phases_run = 0;

   function automatic longint signed scale_q(longint signed a, longint unsigned b,
                                             longint unsigned d, int sh);
      longint unsigned m, p;
      m = (a < 0) ? -a : a;
      if (b != 0 && m > PROD_CAP / b) p = PROD_CAP;
      else p = m * b;
      if (d == 0) d = 1;
      p = (p / d) >> sh;
      return (a < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint signed sat32(longint signed v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [31:0] friction_torque_of(logic signed [31:0] vel);
      longint unsigned dt, kdt, bf, g, gv, h, ctc;
      longint signed w, e, wst, tst, fr;
      w = vel;
      dt = (dt_r == 0) ? 1 : dt_r;
      kdt = (kf_r * dt) >> 32;
      bf = (64'd1 << 48) / dt;
      if (tv_r >= kdt + bf) bf = tv_r - kdt + 1;
      g = kdt + bf;
      gv = g + tv_r;
      e = defl_r;
      wst = w + scale_q(e, kf_r, g, 0);
      tst = scale_q(wst, g, 1, 16);
      h = tv_r - (tv_r * tv_r) / gv;
      ctc = tc_r - (tc_r * tv_r) / gv;
      if (tst > longint'(tc_r)) fr = longint'(ctc) + scale_q(wst, h, 1, 16);
      else if (tst < -longint'(tc_r)) fr = -longint'(ctc) + scale_q(wst, h, 1, 16);
      else fr = tst;
      fr = sat32(fr);
      defl_r = sat32(e - scale_q(e, kdt, g, 0) + scale_q(fr, dt, g, 16));
      return fr[31:0];
   endfunction

   // Sample driver and predictor.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            torque_q.push_back(friction_torque_of(req.joint_velocity));
            samples_sent++;
         end
         if (!req.valid || req.ready) begin
            if (velocity_q.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
               req.valid <= 1'b1;
               req.joint_velocity <= velocity_q.pop_front();
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Torque monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            torques_seen++;
            if (torque_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected torque transfer: %0d", rsp.friction_torque);
            end else begin
               logic signed [31:0] want;
               want = torque_q.pop_front();
               if (rsp.friction_torque !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Torque mismatch: expected %0d, got %0d", want,
                              rsp.friction_torque);
               end
            end
         end
         rsp.ready <= calm || ($urandom_range(99) >= 15);
      end
   end

   task automatic write_reg(logic [ieucf_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [31:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      @(posedge clock);
      while (!(csr.valid && csr.ready)) @(posedge clock);
      csr.valid <= 1'b0;
      case (idx)
         ieucf_pkg::CSR_COULOMB:   tc_r = value[30:0];
         ieucf_pkg::CSR_VISCOUS:   tv_r = value[30:0];
         ieucf_pkg::CSR_STIFFNESS: kf_r = value[30:0];
         ieucf_pkg::CSR_PERIOD:    dt_r = value;
      endcase
   endtask

   task automatic drain();
      @(posedge clock);
      while (velocity_q.size() > 0 || req.valid || torque_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      phases_run++;
   endtask

   function automatic logic [31:0] rand_scaled();
      return $urandom() >> $urandom_range(31);
   endfunction

   function automatic logic signed [31:0] rand_velocity();
      logic signed [31:0] v;
      case ($urandom_range(3))
         0: v = $urandom();
         1: v = $signed($urandom()) >>> $urandom_range(31);
         2: v = $signed($urandom_range(131072)) - 32'sd65536;
         default: v = $signed($urandom()) >>> (10 + $urandom_range(14));
      endcase
      return v;
   endfunction

   task automatic directed_velocities();
      velocity_q.push_back(32'sd0);
      velocity_q.push_back(32'sh7FFF_FFFF);
      velocity_q.push_back(32'sh8000_0000);
      velocity_q.push_back(32'sd1);
      velocity_q.push_back(-32'sd1);
      velocity_q.push_back(32'sd65536);
      velocity_q.push_back(-32'sd65536);
      velocity_q.push_back(32'sh7FFF_FFFF);
      velocity_q.push_back(32'sh7FFF_FFFF);
      velocity_q.push_back(32'sh8000_0000);
      velocity_q.push_back(32'sd0);
      velocity_q.push_back(32'sd0);
   endtask

   initial begin
      tc_r = 0; tv_r = 0; kf_r = 0; dt_r = ieucf_pkg::PERIOD_RESET; defl_r = 0;
      req.valid = 1'b0; req.joint_velocity = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.index = ieucf_pkg::CSR_COULOMB; csr.data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Reset register values, then all at their upper extremes.
      directed_velocities();
      drain();
      write_reg(ieucf_pkg::CSR_COULOMB, 32'hFFFF_FFFF);
      write_reg(ieucf_pkg::CSR_VISCOUS, 32'h7FFF_FFFF);
      write_reg(ieucf_pkg::CSR_STIFFNESS, 32'h7FFF_FFFF);
      write_reg(ieucf_pkg::CSR_PERIOD, 32'hFFFF_FFFF);
      directed_velocities();
      drain();
      for (int ph = 0; ph < 10; ph++) begin
         calm = (ph == 3);
         write_reg(ieucf_pkg::CSR_COULOMB, rand_scaled());
         write_reg(ieucf_pkg::CSR_VISCOUS, rand_scaled());
         write_reg(ieucf_pkg::CSR_STIFFNESS, rand_scaled());
         case (ph)
            1: write_reg(ieucf_pkg::CSR_PERIOD, 32'd0);
            2: write_reg(ieucf_pkg::CSR_PERIOD, 32'hFFFF_FFFF);
            4: write_reg(ieucf_pkg::CSR_PERIOD, 32'd1);
            default: write_reg(ieucf_pkg::CSR_PERIOD, rand_scaled());
         endcase
         repeat (162) velocity_q.push_back(rand_velocity());
         drain();
      end
      calm = 1'b0;
      $display("Covered %0d samples and %0d torques over %0d register settings.",
               samples_sent, torques_seen, phases_run);
      $display("Torque mismatches counted: %0d", mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #300_000_000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
